// ===== src/itrt_pkg.sv =====
// Shared types, constants and the digit-to-character function of the radix text unit.
package itrt_pkg;

   // Field and register widths.
   localparam int NUMBER_W    = 32;
   localparam int RADIX_W     = 6;
   localparam int DIGIT_W     = 6;
   localparam int CHAR_W      = 8;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   // Register index, radix reset value and the supported radix range.
   localparam logic REG_RADIX = 1'b0;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

   // Long division: quotient bits resolved per cycle and division steps per digit.
   localparam int DIV_BITS  = 8;
   localparam int DIV_STEPS = NUMBER_W / DIV_BITS;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   // Character codes.
   localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2d;
   localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_LOWER  = 8'h61;
   localparam logic [DIGIT_W-1:0] DECIMAL    = 6'd10;
   localparam logic [DIGIT_W-1:0] DIGIT_TOP  = 6'd35;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SIGN,
      ST_FETCH,
      ST_EMIT
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic div_step;
      logic emit_sign;
      logic emit_digit;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic step_last;
      logic div_done;
      logic is_neg;
      logic last_digit;
      logic out_free;
   } dp_status_type;

   // Maps a digit value to its ASCII character, 0-9 then a-z.
   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [DIGIT_W-1:0] dc;
      dc = (d > DIGIT_TOP) ? DIGIT_TOP : d;
      if (dc < DECIMAL) begin
         return CHAR_ZERO + CHAR_W'(dc);
      end
      return CHAR_LOWER + CHAR_W'(dc - DECIMAL);
   endfunction

endpackage

// ===== src/itrt_ctrl.sv =====
// Controller state machine that sequences division, sign and digit output.
module itrt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  itrt_pkg::dp_status_type status,
   output itrt_pkg::ctrl_cmd_type  cmd,
   output logic                   busy
);
   import itrt_pkg::*;

   ctrl_state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.step_last && status.div_done) state_in = ST_SIGN;
         end
         ST_SIGN: begin
            if (!status.is_neg || status.out_free) state_in = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = status.last_digit ? ST_IDLE : ST_FETCH;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = req_valid;
         end
         ST_DIVIDE: cmd.div_step   = 1'b1;
         ST_SIGN:   cmd.emit_sign  = status.is_neg && status.out_free;
         ST_FETCH:  cmd            = '0;
         ST_EMIT:   cmd.emit_digit = status.out_free;
         default:   cmd            = '0;
      endcase
   end

endmodule

// ===== src/itrt_dpath.sv =====
// Datapath: magnitude divider, digit store, digit counter and output register.
module itrt_dpath #(
   parameter int MAX_DIGITS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic signed [itrt_pkg::NUMBER_W-1:0]   number,
   input  logic [itrt_pkg::RADIX_W-1:0]           radix,
   input  itrt_pkg::ctrl_cmd_type                  cmd,
   output itrt_pkg::dp_status_type                 status,
   input  logic                                   rsp_stall,
   output logic                                   rsp_valid,
   output logic [itrt_pkg::CHAR_W-1:0]            rsp_char_code,
   output logic                                   rsp_is_last
);
   import itrt_pkg::*;

   localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
   localparam int ADDR_W = $clog2(MAX_DIGITS);

   logic [NUMBER_W-1:0] mag_ff, mag_in, mag_v;
   logic [DIGIT_W-1:0]  rem_ff, rem_v;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                neg_ff, neg_in;
   logic [DIGIT_W:0]    trial;
   logic [ADDR_W-1:0]   rd_addr;
   logic [DIGIT_W-1:0]  rd_ff;
   logic                valid_ff, valid_in;
   logic [CHAR_W-1:0]   char_ff, char_in;
   logic                last_ff, last_in;
   logic [DIGIT_W-1:0]  store_mem [MAX_DIGITS];

   // Eight restoring division steps per cycle; the remainder restarts at each digit.
   always_comb begin
      rem_v = (step_ff == '0) ? '0 : rem_ff;
      mag_v = mag_ff;
      trial = '0;
      for (int k = 0; k < DIV_BITS; k++) begin
         trial = {rem_v, mag_v[NUMBER_W-1]};
         mag_v = {mag_v[NUMBER_W-2:0], 1'b0};
         if (trial >= {1'b0, radix}) begin
            trial    = trial - {1'b0, radix};
            mag_v[0] = 1'b1;
         end
         rem_v = trial[DIGIT_W-1:0];
      end
   end

   // Status towards the controller.
   always_comb begin
      status.step_last  = (step_ff == STEP_W'(DIV_STEPS - 1));
      status.div_done   = (mag_v == '0) || (count_ff == CNT_W'(MAX_DIGITS - 1));
      status.is_neg     = neg_ff;
      status.last_digit = (count_ff == CNT_W'(1));
      status.out_free   = !valid_ff || !rsp_stall;
   end

   // Next values of the division and counting registers.
   always_comb begin
      mag_in   = mag_ff;
      step_in  = step_ff;
      count_in = count_ff;
      neg_in   = neg_ff;
      if (cmd.load) begin
         neg_in   = number[NUMBER_W-1];
         mag_in   = number[NUMBER_W-1] ? (NUMBER_W'(0) - NUMBER_W'(number))
                                       : NUMBER_W'(number);
         step_in  = '0;
         count_in = '0;
      end else if (cmd.div_step) begin
         mag_in  = mag_v;
         step_in = status.step_last ? '0 : step_ff + STEP_W'(1);
         if (status.step_last) count_in = count_ff + CNT_W'(1);
      end else if (cmd.emit_digit) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         count_ff <= '0;
         neg_ff   <= 1'b0;
         mag_ff   <= '0;
      end else begin
         step_ff  <= step_in;
         count_ff <= count_in;
         neg_ff   <= neg_in;
         mag_ff   <= mag_in;
      end
   end

   // The partial remainder carries no control meaning and needs no reset.
   always_ff @(posedge clock) begin
      if (cmd.div_step) rem_ff <= rem_v;
   end

   // Digit store: written least significant first, read back from the top down.
   assign rd_addr = ADDR_W'(count_ff - CNT_W'(1));

   always_ff @(posedge clock) begin
      if (cmd.div_step && status.step_last) begin
         store_mem[count_ff[ADDR_W-1:0]] <= rem_v;
      end
      rd_ff <= store_mem[rd_addr];
   end

   // Output register holding one character item.
   always_comb begin
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (cmd.emit_sign) begin
         valid_in = 1'b1;
         char_in  = CHAR_MINUS;
         last_in  = 1'b0;
      end else if (cmd.emit_digit) begin
         valid_in = 1'b1;
         char_in  = digit_char(rd_ff);
         last_in  = status.last_digit;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_is_last   = last_ff;

endmodule

// ===== src/integer_to_radix_text_unit.sv =====
// Top level of the integer to radix text unit: register port, controller and datapath.
//
// Each accepted item is a signed 32-bit number; the unit answers with its text in the
// radix held in the radix register (0 and 1 act as 2, 37 and above act as 36), one
// ASCII character item at a time, most significant first, with a leading '-' for
// negative values and is_last set on the final digit. Zero gives "0". Digits are
// found by long division resolving eight quotient bits per cycle. Output then reads
// each digit from the digit store and passes it to the output register, after a sign
// step which positive numbers pass through as well; sign and digit output wait while
// the result side stalls. The unit then returns to idle, where the next item is taken
// in the cycle after the last character has entered the output register.
module integer_to_radix_text_unit #(
   parameter int MAX_DIGITS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [itrt_pkg::NUMBER_W-1:0]   req_number,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [itrt_pkg::CHAR_W-1:0]            rsp_char_code,
   output logic                                   rsp_is_last,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [itrt_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [itrt_pkg::CSR_DATA_W-1:0]        pwdata,
   output logic [itrt_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                   pready
);
   import itrt_pkg::*;

   logic [RADIX_W-1:0] radix_ff, radix_in;
   logic [RADIX_W-1:0] radix_eff;
   logic               reg_index;
   logic               busy;
   ctrl_cmd_type       cmd;
   dp_status_type      status;

   // Register port: one register, read and written without wait states.
   assign pready    = 1'b1;
   assign reg_index = paddr[2];

   always_comb begin
      radix_in = radix_ff;
      if (psel && penable && pwrite && pready && (reg_index == REG_RADIX)) begin
         radix_in = pwdata[RADIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else begin
         radix_ff <= radix_in;
      end
   end

   assign prdata = (reg_index == REG_RADIX) ? {(CSR_DATA_W - RADIX_W)'(0), radix_ff}
                                            : '0;

   // Clamp the register to the supported range of bases.
   always_comb begin
      radix_eff = radix_ff;
      if (radix_ff < RADIX_MIN) radix_eff = RADIX_MIN;
      if (radix_ff > RADIX_MAX) radix_eff = RADIX_MAX;
   end

   assign req_stall = busy;

   itrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy)
   );

   itrt_dpath #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .number        (req_number),
      .radix         (radix_eff),
      .cmd           (cmd),
      .status        (status),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_char_code (rsp_char_code),
      .rsp_is_last   (rsp_is_last)
   );

endmodule

// ===== test/integer_to_radix_text_unit_test.sv =====
// Self-checking testbench for the integer to radix text unit, with random flow control.
module integer_to_radix_text_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import itrt_pkg::*;

   localparam int RESET_CYCLES  = 12;
   localparam int CYCLE_LIMIT   = 800000;
   localparam int IDLE_PCT      = 32;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 40;
   localparam int PHASE_ITEMS   = 30;
   // Register index just past the end of the register list.
   localparam int REG_SPARE     = 1;

   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              is_last;
   } text_char_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic signed [NUMBER_W-1:0]  req_number = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [CHAR_W-1:0]           rsp_char_code;
   logic                        rsp_is_last;
   logic                        psel = 1'b0;
   logic                        penable = 1'b0;
   logic                        pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]       paddr = '0;
   logic [CSR_DATA_W-1:0]       pwdata = '0;
   logic [CSR_DATA_W-1:0]       prdata;
   logic                        pready;

   // Local copy of the radix register, the numbers still to be sent and the text still owed.
   logic [RADIX_W-1:0]          radix_now = RADIX_RESET;
   logic [NUMBER_W-1:0]         numbers_pending[$];
   text_char_type               text_due[$];
   int                          numbers_queued = 0;
   int                          numbers_taken = 0;
   int                          errors = 0;
   int                          cycles = 0;
   int                          hold_asked = 0;
   int                          hold_done = 0;
   int                          hold_left = 0;
   logic                        calm = 1'b0;
   logic                        req_taken = 1'b0;

   integer_to_radix_text_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_number(req_number),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_char_code(rsp_char_code),
      .rsp_is_last(rsp_is_last),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #6 clock = ~clock;

   // Works out the characters of one number in the current radix and queues them.
   function automatic void predict_text(input logic [NUMBER_W-1:0] number);
      logic [RADIX_W-1:0]  base;
      logic [NUMBER_W-1:0] magnitude;
      logic [DIGIT_W-1:0]  digits[$];
      logic [DIGIT_W-1:0]  d;
      text_char_type       c;
      base = radix_now;
      if (base < RADIX_MIN) begin
         base = RADIX_MIN;
      end else if (base > RADIX_MAX) begin
         base = RADIX_MAX;
      end
      // The magnitude is unsigned, so the most negative number needs no special handling.
      magnitude = number[NUMBER_W-1] ? (32'd0 - number) : number;
      do begin
         digits.push_front(DIGIT_W'(magnitude % base));
         magnitude = magnitude / base;
      end while (magnitude != 0);
      if (number[NUMBER_W-1]) begin
         c.code = CHAR_MINUS;
         c.is_last = 1'b0;
         text_due.push_back(c);
      end
      for (int i = 0; i < digits.size(); i++) begin
         d = digits[i];
         c.code = (d < DECIMAL) ? CHAR_ZERO + CHAR_W'(d) : CHAR_LOWER + CHAR_W'(d - DECIMAL);
         c.is_last = (i == digits.size() - 1);
         text_due.push_back(c);
      end
   endfunction

   // A mix of full-range, small and shortened numbers of either sign.
   function automatic logic [NUMBER_W-1:0] random_number();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(2000) - 1000;
         2: return $urandom >> $urandom_range(31);
         default: return 32'd0 - ($urandom >> $urandom_range(31));
      endcase
   endfunction

   task automatic offer(input logic [NUMBER_W-1:0] number);
      numbers_pending.push_back(number);
      numbers_queued++;
   endtask

   // Waits until every number has been taken and all its text has come back.
   task automatic settle(input int extra);
      while (numbers_taken != numbers_queued || text_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (extra) @(negedge clock);
   endtask

   task automatic csr_write(input int index, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_W'(4 * index);
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (index == REG_RADIX) begin
         radix_now = value[RADIX_W-1:0];
      end
   endtask

   task automatic csr_check(input int index, input logic [CSR_DATA_W-1:0] want);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= CSR_ADDR_W'(4 * index);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== want) begin
         $display("%0t: register %0d read expected %h actual %h", $time, index, want, prdata);
         errors++;
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // Number driver: a new item is presented only once the previous one has been taken.
   always @(negedge clock) begin : number_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (numbers_pending.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
            req_number <= numbers_pending.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Text receiver: random stalls, or a long hold-off when one is asked for.
   always @(negedge clock) begin : text_receiver
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_asked != hold_done) begin
         hold_done <= hold_done + 1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // Monitor: predicts on every accepted number and checks every accepted character.
   always @(posedge clock) begin : text_monitor
      text_char_type due;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            predict_text(req_number);
            numbers_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (text_due.size() == 0) begin
               $display("%0t: unexpected character expected none actual %h last %b",
                        $time, rsp_char_code, rsp_is_last);
               errors++;
            end else begin
               due = text_due.pop_front();
               if (rsp_char_code !== due.code) begin
                  $display("%0t: char_code expected %h actual %h",
                           $time, due.code, rsp_char_code);
                  errors++;
               end
               if (rsp_is_last !== due.is_last) begin
                  $display("%0t: is_last expected %b actual %b",
                           $time, due.is_last, rsp_is_last);
                  errors++;
               end
            end
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin : watchdog
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d characters outstanding", $time, text_due.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      logic [RADIX_W-1:0]    radix_plan[$];
      logic [CSR_DATA_W-1:0] data;
      radix_plan = '{6'd2, 6'd36, 6'd0, 6'd63, 6'd1, 6'd37, 6'd16, 6'd8, 6'd10, 6'd7, 6'd35};
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Directed numbers in the reset radix: zero, sign and width extremes, digit roll-overs.
      offer(0);
      offer(1);
      offer(-1);
      offer(9);
      offer(10);
      offer(-10);
      offer(99);
      offer(100);
      offer(32'h7fffffff);
      offer(32'h80000000);
      offer(32'h80000001);
      offer(123456789);
      offer(-987654321);
      offer(32'h55555555);
      offer(32'haaaaaaaa);
      offer(1000000000);
      offer(-1000000000);
      settle(SETTLE_CYCLES);

      // One phase per radix setting, including values that must be clamped.
      foreach (radix_plan[p]) begin
         data = $urandom;
         data[RADIX_W-1:0] = radix_plan[p];
         csr_write(REG_RADIX, data);
         // A write past the register list must leave the radix alone.
         if (p == 4) begin
            csr_write(REG_SPARE, $urandom);
         end
         csr_check(REG_RADIX, CSR_DATA_W'(radix_plan[p]));
         calm = (p == 3);
         offer(0);
         offer(32'h7fffffff);
         offer(32'h80000000);
         offer(-1);
         offer(1);
         // Hold the text side off for a long while so that the unit backs up.
         if (p == 8) begin
            hold_asked++;
         end
         repeat (PHASE_ITEMS - 5) offer(random_number());
         settle(SETTLE_CYCLES);
      end
      calm = 1'b0;

      settle(DRAIN_CYCLES);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
